// File: rtl/bpns_pkg.sv
package bpns_pkg;

    localparam int SEG_BITS    = 64;
    localparam int FRAC_BITS   = 20;
    localparam int CHUNK_BITS  = 16;
    localparam int NUM_CHUNKS  = SEG_BITS / CHUNK_BITS;
    localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
    localparam int LEN_W       = 7;
    localparam int POS_W       = 4;
    localparam int POP_W       = 7;
    localparam int CPOP_W      = $clog2(CHUNK_BITS + 1);
    localparam int TENTHS_W    = 11;
    localparam int NUM_W       = 30;
    localparam int DEN_W       = 14;
    localparam int DIV_CNT_W   = $clog2(NUM_W);
    localparam int SEG_W       = 18;
    localparam int TOTAL_W     = 21;
    localparam int SUM_W       = 23;

    localparam int WDIV_HEAVY   = 10;
    localparam int WDIV_LIGHT   = 20;
    localparam int TENTHS_SCALE = 10;

    localparam logic [POS_W-1:0] SPLIT_RESET = POS_W'(6);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLASS,
        S_SCAN,
        S_SETUP,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic classify;
        logic scan;
        logic div_start;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_last;
        logic div_done;
        logic out_free;
    } t_status;

    function automatic logic [CPOP_W-1:0] popcnt(input logic [CHUNK_BITS-1:0] v);
        logic [CPOP_W-1:0] n;
        n = '0;
        for (int i = 0; i < CHUNK_BITS; i++) begin
            n = n + CPOP_W'(v[i]);
        end
        return n;
    endfunction

endpackage

// File: rtl/bit_pattern_nearness_score_core.sv
// Scores one pair of bit-pattern hash segments per transaction and keeps a
// running total over the segments of one hash pair.
// Input channel: i_in_valid / o_in_stall with bits_a, bits_b, segment_length,
// segment_position and last_segment. A transaction completes on a rising
// edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall with segment_score (signed, 20
// fraction bits), total_score (clamped at zero) and is_final. One result
// per input transaction, in order.
// Config channel: i_cfg_valid / o_cfg_ready writes the 4-bit weight split
// position; o_cfg_ready is always high. Write it only while idle.
// Steps: classify, scan the four 16-bit slices, set up, run the radix-2
// divider (30 quotient bits, one per cycle) and write out; write-out
// waits until the output register is free.
// Segments are taken one at a time: the input stalls until a result is written.
// A new transaction is taken while a result still waits in the output
// register; if the receiver stalls, the next result holds inside the block
// until the output register frees.
// Reset (synchronous, active low): running total cleared, split set to 6,
// no output pending.
module bit_pattern_nearness_score_core
    import bpns_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [POS_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [SEG_BITS-1:0]     i_bits_a,
    input  logic [SEG_BITS-1:0]     i_bits_b,
    input  logic [LEN_W-1:0]        i_segment_length,
    input  logic [POS_W-1:0]        i_segment_position,
    input  logic                    i_last_segment,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [SEG_W-1:0] o_segment_score,
    output logic [TOTAL_W-1:0]      o_total_score,
    output logic                    o_is_final
);

    t_cmd    s_cmd;
    t_status s_status;

    assign o_cfg_ready = 1'b1;

    bpns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (s_status),
        .o_cmd      (s_cmd)
    );

    bpns_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (s_cmd),
        .o_status           (s_status),
        .i_cfg_we           (i_cfg_valid && o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_bits_a           (i_bits_a),
        .i_bits_b           (i_bits_b),
        .i_segment_length   (i_segment_length),
        .i_segment_position (i_segment_position),
        .i_last_segment     (i_last_segment),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_segment_score    (o_segment_score),
        .o_total_score      (o_total_score),
        .o_is_final         (o_is_final)
    );

`ifndef ASSERT_OFF
    a_accept_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a segment is in progress");

    a_finish_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.finish |-> (!o_out_valid || !i_out_stall))
        else $error("result written over a pending output");

    a_start_clears_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.div_start |=> !s_status.div_done)
        else $error("divider done flag not cleared on start");
`endif

endmodule

// File: rtl/bpns_div.sv
module bpns_div
    import bpns_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_done
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_quo;
    logic [DEN_W-1:0]     r_rem;
    logic [DEN_W-1:0]     r_den;

    logic [DEN_W:0]       w_trial;
    logic                 w_ge;
    logic [DEN_W:0]       w_diff;

    // one restoring step per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == DIV_CNT_W'(NUM_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

// File: rtl/bpns_ctrl.sv
module bpns_ctrl
    import bpns_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.scan_last) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_CLASS: begin
                o_cmd.classify = 1'b1;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_SETUP: begin
                o_cmd.div_start = 1'b1;
            end
            S_DIV: begin
                o_cmd = '0;
            end
            S_DONE: begin
                o_cmd.finish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/bpns_dp.sv
module bpns_dp
    import bpns_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  logic                    i_cfg_we,
    input  logic [POS_W-1:0]        i_cfg_data,
    input  logic [SEG_BITS-1:0]     i_bits_a,
    input  logic [SEG_BITS-1:0]     i_bits_b,
    input  logic [LEN_W-1:0]        i_segment_length,
    input  logic [POS_W-1:0]        i_segment_position,
    input  logic                    i_last_segment,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [SEG_W-1:0] o_segment_score,
    output logic [TOTAL_W-1:0]      o_total_score,
    output logic                    o_is_final
);

    logic [POS_W-1:0]            r_split;
    logic [SEG_BITS-1:0]         r_a;
    logic [SEG_BITS-1:0]         r_b;
    logic                        r_heavy;
    logic                        r_last;
    logic [SEG_BITS-1:0]         r_h0;
    logic [SEG_BITS-1:0]         r_h1;
    logic [SEG_BITS-1:0]         r_h2;
    logic [SEG_BITS-1:0]         r_h4;
    logic [SEG_BITS-1:0]         r_hb;
    logic                        r_eq;
    logic [CHUNK_IDX_W-1:0]      r_chunk;
    logic [POP_W-1:0]            r_pa;
    logic [POP_W-1:0]            r_pb;
    logic [TENTHS_W-1:0]         r_tenths;
    logic                        r_neg;
    logic signed [SUM_W-1:0]     r_sum;
    logic                        r_out_valid;
    logic [SEG_W-1:0]            r_seg_out;
    logic [TOTAL_W-1:0]          r_total_out;
    logic                        r_final_out;

    logic [SEG_BITS-1:0]         w_mask;
    logic [SEG_BITS-1:0]         w_nb1;
    logic [SEG_BITS-1:0]         w_nb23;
    logic [CPOP_W-1:0]           w_c0;
    logic [CPOP_W-1:0]           w_c1;
    logic [CPOP_W-1:0]           w_c2;
    logic [CPOP_W-1:0]           w_c4;
    logic [CPOP_W-1:0]           w_cb;
    logic [TENTHS_W-1:0]         w_ct;
    logic [POP_W-1:0]            w_m;
    logic [POP_W:0]              w_s;
    logic [TENTHS_W-1:0]         w_mag;
    logic [NUM_W-1:0]            w_num;
    logic [DEN_W-1:0]            w_den;
    logic                        w_neg;
    logic [NUM_W-1:0]            w_quo;
    logic                        w_div_done;
    logic [SEG_W-1:0]            w_q;
    logic [SEG_W-1:0]            w_seg;
    logic [SUM_W:0]              w_sum_ext;
    logic [SUM_W-1:0]            w_sat;
    logic [TOTAL_W-1:0]          w_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= SPLIT_RESET;
        end else if (i_cfg_we) begin
            r_split <= i_cfg_data;
        end
    end

    always_comb begin
        for (int i = 0; i < SEG_BITS; i++) begin
            w_mask[i] = (i_segment_length > LEN_W'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a     <= i_bits_a & w_mask;
            r_b     <= i_bits_b & w_mask;
            r_heavy <= (i_segment_position < r_split);
            r_last  <= i_last_segment;
        end
    end

    // distance classes of each set bit of a against b
    always_comb begin
        w_nb1  = (r_b << 1) | (r_b >> 1);
        w_nb23 = (r_b << 2) | (r_b >> 2) | (r_b << 3) | (r_b >> 3);
    end

    always_comb begin
        w_c0 = popcnt(r_h0[CHUNK_BITS-1:0]);
        w_c1 = popcnt(r_h1[CHUNK_BITS-1:0]);
        w_c2 = popcnt(r_h2[CHUNK_BITS-1:0]);
        w_c4 = popcnt(r_h4[CHUNK_BITS-1:0]);
        w_cb = popcnt(r_hb[CHUNK_BITS-1:0]);
        w_ct = TENTHS_W'(w_c0) * TENTHS_W'(10) + TENTHS_W'(w_c1)
             - TENTHS_W'(w_c2) * TENTHS_W'(2) - TENTHS_W'(w_c4) * TENTHS_W'(5);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.classify) begin
            r_h0     <= r_a & r_b;
            r_h1     <= r_a & ~r_b & w_nb1;
            r_h2     <= r_a & ~r_b & ~w_nb1 & w_nb23;
            r_h4     <= r_a & ~(r_b | w_nb1 | w_nb23);
            r_hb     <= r_b;
            r_eq     <= (r_a == r_b);
            r_pa     <= '0;
            r_pb     <= '0;
            r_tenths <= '0;
        end else if (i_cmd.scan) begin
            r_h0     <= r_h0 >> CHUNK_BITS;
            r_h1     <= r_h1 >> CHUNK_BITS;
            r_h2     <= r_h2 >> CHUNK_BITS;
            r_h4     <= r_h4 >> CHUNK_BITS;
            r_hb     <= r_hb >> CHUNK_BITS;
            r_pa     <= r_pa + POP_W'(w_c0) + POP_W'(w_c1) + POP_W'(w_c2) + POP_W'(w_c4);
            r_pb     <= r_pb + POP_W'(w_cb);
            r_tenths <= r_tenths + w_ct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
        end else if (i_cmd.classify) begin
            r_chunk <= '0;
        end else if (i_cmd.scan) begin
            r_chunk <= r_chunk + 1'b1;
        end
    end

    // divider operands
    always_comb begin
        w_m   = (r_pa > r_pb) ? r_pa : r_pb;
        w_s   = {1'b0, r_pa} + {1'b0, r_pb} + 1'b1;
        w_mag = r_tenths[TENTHS_W-1] ? (~r_tenths + 1'b1) : r_tenths;
        w_neg = 1'b0;
        if (r_eq) begin
            w_num = NUM_W'(1) << FRAC_BITS;
            w_den = r_heavy ? DEN_W'(WDIV_HEAVY) : DEN_W'(WDIV_LIGHT);
        end else if (r_pa == '0 || r_pb == '0) begin
            w_num = NUM_W'(1) << FRAC_BITS;
            w_den = DEN_W'(w_s) * (r_heavy ? DEN_W'(WDIV_HEAVY) : DEN_W'(WDIV_LIGHT));
        end else begin
            w_num = NUM_W'(w_mag) << FRAC_BITS;
            w_den = DEN_W'(w_m) * (r_heavy ? DEN_W'(WDIV_HEAVY * TENTHS_SCALE)
                                           : DEN_W'(WDIV_LIGHT * TENTHS_SCALE));
            w_neg = r_tenths[TENTHS_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_neg <= w_neg;
        end
    end

    bpns_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    // signed score, saturating running sum, clamped total
    always_comb begin
        w_q       = w_quo[SEG_W-1:0];
        w_seg     = r_neg ? (~w_q + 1'b1) : w_q;
        w_sum_ext = {r_sum[SUM_W-1], r_sum}
                  + {{(SUM_W + 1 - SEG_W){w_seg[SEG_W-1]}}, w_seg};
        if (w_sum_ext[SUM_W] != w_sum_ext[SUM_W-1]) begin
            w_sat = w_sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                     : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            w_sat = w_sum_ext[SUM_W-1:0];
        end
        if (w_sat[SUM_W-1]) begin
            w_total = '0;
        end else if (|w_sat[SUM_W-2:TOTAL_W]) begin
            w_total = '1;
        end else begin
            w_total = w_sat[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_sum       <= r_last ? '0 : $signed(w_sat);
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_seg_out   <= w_seg;
            r_total_out <= w_total;
            r_final_out <= r_last;
        end
    end

    always_comb begin
        o_status.scan_last = (r_chunk == CHUNK_IDX_W'(NUM_CHUNKS - 1));
        o_status.div_done  = w_div_done;
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_segment_score = $signed(r_seg_out);
    assign o_total_score   = r_total_out;
    assign o_is_final      = r_final_out;

endmodule

// File: sim/bpns_score_checker.sv
module bpns_score_checker
    import bpns_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic                    o_cfg_ready,
    input  logic [POS_W-1:0]        i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    o_in_stall,
    input  logic [SEG_BITS-1:0]     i_bits_a,
    input  logic [SEG_BITS-1:0]     i_bits_b,
    input  logic [LEN_W-1:0]        i_segment_length,
    input  logic [POS_W-1:0]        i_segment_position,
    input  logic                    i_last_segment,
    input  logic                    o_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [SEG_W-1:0] o_segment_score,
    input  logic [TOTAL_W-1:0]      o_total_score,
    input  logic                    o_is_final,
    output int                      o_errors,
    output int                      o_pending
);

    localparam longint SUM_HI   = (longint'(1) << (SUM_W - 1)) - 1;
    localparam longint SUM_LO   = -(longint'(1) << (SUM_W - 1));
    localparam longint TOTAL_HI = (longint'(1) << TOTAL_W) - 1;

    typedef struct packed {
        logic signed [SEG_W-1:0] score;
        logic [TOTAL_W-1:0]      total;
        logic                    done;
    } t_seg_result;

    t_seg_result             expected_q[$];
    logic [POS_W-1:0]        split;
    logic signed [SUM_W-1:0] running_sum;
    int                      errors = 0;

    assign o_errors = errors;

    function automatic int gap_to_nearest(input int i, input logic [SEG_BITS-1:0] b);
        int best;
        int d;
        best = SEG_BITS;
        for (int j = 0; j < SEG_BITS; j++) begin
            if (b[j]) begin
                d = (i > j) ? i - j : j - i;
                if (d < best) begin
                    best = d;
                end
            end
        end
        return best;
    endfunction

    function automatic longint nearness_score(input logic [SEG_BITS-1:0] a,
                                              input logic [SEG_BITS-1:0] b,
                                              input logic [LEN_W-1:0] len,
                                              input bit heavy);
        logic [SEG_BITS-1:0] mask;
        longint one;
        longint wdiv;
        longint tenths;
        int eff_len;
        int pa;
        int pb;
        int m;
        int d;
        one = longint'(1) << FRAC_BITS;
        wdiv = heavy ? WDIV_HEAVY : WDIV_LIGHT;
        eff_len = (int'(len) > SEG_BITS) ? SEG_BITS : int'(len);
        mask = (eff_len >= SEG_BITS) ? '1 : ((64'd1 << eff_len) - 64'd1);
        a = a & mask;
        b = b & mask;
        if (a == b) begin
            return (TENTHS_SCALE * one) / (TENTHS_SCALE * wdiv);
        end
        pa = $countones(a);
        pb = $countones(b);
        if (pa == 0 || pb == 0) begin
            return one / (wdiv * longint'(pa + pb + 1));
        end
        m = (pa > pb) ? pa : pb;
        tenths = 0;
        for (int i = 0; i < SEG_BITS; i++) begin
            if (a[i]) begin
                d = gap_to_nearest(i, b);
                if (d == 0) begin
                    tenths += 10;
                end else if (d == 1) begin
                    tenths += 1;
                end else if (d < 4) begin
                    tenths -= 2;
                end else begin
                    tenths -= 5;
                end
            end
        end
        return (tenths * one) / (TENTHS_SCALE * wdiv * longint'(m));
    endfunction

    always @(posedge i_clk) begin : watch
        longint      seg;
        longint      sum;
        longint      total;
        t_seg_result want;
        if (!i_rst_n) begin
            split = SPLIT_RESET;
            running_sum = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                split = i_cfg_data;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with no transaction pending: score %0d total %0d",
                             $time, o_segment_score, o_total_score);
                    errors++;
                end else begin
                    want = expected_q.pop_front();
                    if (o_segment_score !== want.score) begin
                        $display("%0t: segment_score expected %0d, got %0d",
                                 $time, want.score, o_segment_score);
                        errors++;
                    end
                    if (o_total_score !== want.total) begin
                        $display("%0t: total_score expected %0d, got %0d",
                                 $time, want.total, o_total_score);
                        errors++;
                    end
                    if (o_is_final !== want.done) begin
                        $display("%0t: is_final expected %0b, got %0b",
                                 $time, want.done, o_is_final);
                        errors++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                seg = nearness_score(i_bits_a, i_bits_b, i_segment_length,
                                     i_segment_position < split);
                sum = longint'(running_sum) + seg;
                if (sum > SUM_HI) begin
                    sum = SUM_HI;
                end
                if (sum < SUM_LO) begin
                    sum = SUM_LO;
                end
                running_sum = sum[SUM_W-1:0];
                total = (sum < 0) ? 0 : sum;
                if (total > TOTAL_HI) begin
                    total = TOTAL_HI;
                end
                want.score = seg[SEG_W-1:0];
                want.total = total[TOTAL_W-1:0];
                want.done = i_last_segment;
                expected_q = {expected_q, want};
                if (i_last_segment) begin
                    running_sum = '0;
                end
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

// File: sim/tb.sv
module tb;
    import bpns_pkg::*;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [POS_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [SEG_BITS-1:0]     i_bits_a = '0;
    logic [SEG_BITS-1:0]     i_bits_b = '0;
    logic [LEN_W-1:0]        i_segment_length = '0;
    logic [POS_W-1:0]        i_segment_position = '0;
    logic                    i_last_segment = 1'b0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [SEG_W-1:0] o_segment_score;
    logic [TOTAL_W-1:0]      o_total_score;
    logic                    o_is_final;

    int errors;
    int pending;
    bit calm = 1'b0;
    int phase_count;
    logic [POS_W-1:0] split_values [6];

    always #2 i_clk = ~i_clk;

    bit_pattern_nearness_score_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_bits_a           (i_bits_a),
        .i_bits_b           (i_bits_b),
        .i_segment_length   (i_segment_length),
        .i_segment_position (i_segment_position),
        .i_last_segment     (i_last_segment),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_segment_score    (o_segment_score),
        .o_total_score      (o_total_score),
        .o_is_final         (o_is_final)
    );

    bpns_score_checker score_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_bits_a           (i_bits_a),
        .i_bits_b           (i_bits_b),
        .i_segment_length   (i_segment_length),
        .i_segment_position (i_segment_position),
        .i_last_segment     (i_last_segment),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_segment_score    (o_segment_score),
        .o_total_score      (o_total_score),
        .o_is_final         (o_is_final),
        .o_errors           (errors),
        .o_pending          (pending)
    );

    always @(posedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(99) < 10);
    end

    function automatic logic [SEG_BITS-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_segment(input logic [SEG_BITS-1:0] a, input logic [SEG_BITS-1:0] b,
                                input logic [LEN_W-1:0] len, input logic [POS_W-1:0] pos,
                                input logic seg_last);
        while (!calm && $urandom_range(99) < 10) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_bits_a <= a;
        i_bits_b <= b;
        i_segment_length <= len;
        i_segment_position <= pos;
        i_last_segment <= seg_last;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        phase_count++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    task automatic write_split(input logic [POS_W-1:0] value);
        drain_results();
        repeat (40) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_hash();
        int nseg;
        logic [SEG_BITS-1:0] a;
        logic [SEG_BITS-1:0] b;
        logic [LEN_W-1:0] len;
        nseg = $urandom_range(16, 1);
        for (int p = 0; p < nseg; p++) begin
            a = rand64();
            if ($urandom_range(3) == 0) begin
                a = a & rand64() & rand64();
            end
            case ($urandom_range(5))
                0: b = a;
                1: b = a ^ (64'd1 << $urandom_range(63)) ^ (64'd1 << $urandom_range(63));
                2: b = a << $urandom_range(4, 1);
                3: b = a >> $urandom_range(4, 1);
                4: b = rand64() & rand64() & rand64();
                default: b = $urandom_range(1) ? '0 : rand64();
            endcase
            case ($urandom_range(9))
                0, 1, 2, 3, 4: len = LEN_W'(SEG_BITS);
                5, 6, 7: len = LEN_W'(36);
                default: len = LEN_W'($urandom_range(127));
            endcase
            send_segment(a, b, len, POS_W'(p), p == nseg - 1);
        end
    endtask

    initial begin
        split_values = '{4'd0, 4'd15, 4'd9, 4'd1, 4'd14, 4'd6};
        split_values[5] = POS_W'($urandom_range(15));
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_segment('0, '0, LEN_W'(64), POS_W'(0), 1'b0);
        send_segment('1, '1, LEN_W'(64), POS_W'(15), 1'b0);
        send_segment('1, '0, LEN_W'(64), POS_W'(0), 1'b0);
        send_segment('0, '1, LEN_W'(64), POS_W'(15), 1'b0);
        send_segment(rand64(), rand64(), LEN_W'(0), POS_W'(3), 1'b0);
        send_segment(64'd1, 64'd1 << 63, LEN_W'(127), POS_W'(0), 1'b0);
        send_segment(64'd1, 64'd1 << 63, LEN_W'(100), POS_W'(15), 1'b0);
        send_segment((64'd1 << 10) | (64'd1 << 20), (64'd1 << 10) | (64'd1 << 21),
                     LEN_W'(64), POS_W'(2), 1'b0);
        send_segment(64'd1 << 5, 64'd1 << 7, LEN_W'(36), POS_W'(5), 1'b0);
        send_segment(64'd1 << 5, 64'd1 << 8, LEN_W'(36), POS_W'(6), 1'b0);
        send_segment(64'd1 << 5, 64'd1 << 9, LEN_W'(36), POS_W'(7), 1'b0);
        send_segment(64'd1 << 40, '0, LEN_W'(36), POS_W'(1), 1'b0);
        send_segment((64'd1 << 35) | 64'd1, 64'd1 << 34, LEN_W'(36), POS_W'(0), 1'b0);
        send_segment(rand64(), rand64(), LEN_W'(64), POS_W'(0), 1'b1);
        send_segment(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                     LEN_W'(64), POS_W'(4), 1'b0);
        send_segment('1, 64'd1, LEN_W'(64), POS_W'(0), 1'b0);
        send_segment(64'd1, '1, LEN_W'(64), POS_W'(0), 1'b0);
        send_segment(rand64(), rand64(), LEN_W'(8), POS_W'(15), 1'b1);

        for (int ph = 0; ph < 6; ph++) begin
            write_split(split_values[ph]);
            calm = (ph == 2);
            if (ph == 1) begin
                // push the running sum into both saturation limits
                for (int k = 0; k < 45; k++) begin
                    send_segment('1, '1, LEN_W'(64), POS_W'(0), k == 44);
                end
                for (int k = 0; k < 90; k++) begin
                    send_segment(64'd1, 64'd1 << 63, LEN_W'(64), POS_W'(0), k == 89);
                end
            end
            phase_count = 0;
            while (phase_count < 280) begin
                if ($urandom_range(9) == 0) begin
                    send_segment(rand64(), rand64(), LEN_W'($urandom_range(127)),
                                 POS_W'($urandom_range(15)), 1'($urandom_range(1)));
                end else begin
                    send_hash();
                end
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("bit_pattern_nearness_score_core test passed");
        end else begin
            $display("bit_pattern_nearness_score_core test failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("bit_pattern_nearness_score_core test failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/bpns_pkg.sv
rtl/bpns_div.sv
rtl/bpns_ctrl.sv
rtl/bpns_dp.sv
rtl/bit_pattern_nearness_score_core.sv
sim/bpns_score_checker.sv
sim/tb.sv
